// ===== hw/rtl/dbad_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Depth background average package
// Field widths, depth codes and item types shared by the background
// averaging block.
// ----------------------------------------------------------------------------
package dbad_pkg;

   localparam int PIXEL_INDEX_W        = 19;
   localparam int DEPTH_W              = 11;
   localparam int WEIGHT_W             = 9;
   localparam int FRAME_PIXELS_DEFAULT = 307200;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 9'd256;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd64;

   localparam logic [DEPTH_W-1:0] DEPTH_NO_DATA_LOW  = 11'd0;
   localparam logic [DEPTH_W-1:0] DEPTH_NO_DATA_HIGH = 11'd2047;

   typedef struct packed {
      logic [PIXEL_INDEX_W-1:0] pixel_index;
      logic [DEPTH_W-1:0]       raw_depth;
   } req_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] average_depth;
      logic [DEPTH_W-1:0] depth_difference;
      logic               both_valid;
   } rsp_type;

   function automatic logic depth_ok(input logic [DEPTH_W-1:0] value);
      return (value != DEPTH_NO_DATA_LOW) && (value != DEPTH_NO_DATA_HIGH);
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/depth_background_average_diff.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Depth background average and difference
// Keeps a running average of raw depth for every pixel and reports the
// updated average together with its distance from the new sample.
// ----------------------------------------------------------------------------
// The block takes one item per clock unless clearing or rsp_stall holds it,
// and returns its result through a read, update and difference stage;
// back-to-back items for the same pixel are served by forwarding the last
// write, so the average store needs one read port and one write port. After
// reset the store is cleared one entry per cycle, keeping req_stall high
// until the last entry is cleared; the weight register may be written meanwhile.
module depth_background_average_diff
   import dbad_pkg::*;
#(
   parameter int FRAME_PIXELS = FRAME_PIXELS_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output rsp_type             rsp_data,
   input  wire                 csr_wr_en,
   input  wire [WEIGHT_W-1:0]  csr_wr_data
);

   localparam int ADDR_W    = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
   localparam int IDX_EXT_W = (ADDR_W > PIXEL_INDEX_W) ? ADDR_W : PIXEL_INDEX_W;
   localparam int SUM_W     = DEPTH_W + WEIGHT_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_PIXELS - 1);

   logic [DEPTH_W-1:0] store_mem [FRAME_PIXELS];

   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic [WEIGHT_W-1:0] weight_inv_ff, weight_inv_in;

   logic                clearing_ff;
   logic [ADDR_W-1:0]   clr_addr_ff;

   logic                s1_valid_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic                s1_in_range_ff;
   logic [DEPTH_W-1:0]  s1_raw_ff;
   logic [DEPTH_W-1:0]  s1_rd_ff;

   logic                s2_valid_ff;
   logic                s2_in_range_ff;
   logic                s2_raw_ok_ff;
   logic [DEPTH_W-1:0]  s2_raw_ff;
   logic [DEPTH_W-1:0]  s2_avg_ff, s2_avg_in;

   logic                s3_valid_ff;
   rsp_type             s3_rsp_ff, s3_rsp_in;

   logic                fwd_valid_ff;
   logic [ADDR_W-1:0]   fwd_addr_ff;
   logic [DEPTH_W-1:0]  fwd_avg_ff;

   logic                s3_ready, s2_ready, s1_ready;
   logic                req_accept;
   logic [IDX_EXT_W-1:0] req_idx_ext;
   logic [ADDR_W-1:0]   req_addr;
   logic                req_in_range;
   logic                s1_raw_ok;
   logic [DEPTH_W-1:0]  s1_avg_cur;
   logic [SUM_W-1:0]    blend_sum;
   logic [DEPTH_W-1:0]  blend_avg;
   logic                mem_wr_en;
   logic                s2_avg_ok;
   logic                s2_both;

   // Handshake and stage advance.
   assign s3_ready   = !s3_valid_ff || !rsp_stall;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_stall  = clearing_ff || !s1_ready;
   assign req_accept = req_valid && !req_stall;

   assign req_idx_ext  = IDX_EXT_W'(req_data.pixel_index);
   assign req_addr     = req_idx_ext[ADDR_W-1:0];
   assign req_in_range = 32'(req_data.pixel_index) < 32'(FRAME_PIXELS);

   // Weight is saturated when written, so the update path sees w and 256-w.
   always_comb begin
      weight_in     = (csr_wr_data > WEIGHT_ONE) ? WEIGHT_ONE : csr_wr_data;
      weight_inv_in = WEIGHT_ONE - weight_in;
   end

   // Update stage: pick the freshest average and blend in the new sample if its depth is usable.
   assign s1_raw_ok  = depth_ok(s1_raw_ff);
   assign s1_avg_cur = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_avg_ff
                                                                    : s1_rd_ff;
   assign blend_sum  = (SUM_W'(s1_raw_ff) * SUM_W'(weight_ff))
                     + (SUM_W'(s1_avg_cur) * SUM_W'(weight_inv_ff));
   assign blend_avg  = blend_sum[DEPTH_W+7:8];
   assign mem_wr_en  = s1_valid_ff && s2_ready && s1_in_range_ff && s1_raw_ok;

   always_comb begin
      if (!s1_in_range_ff) begin
         s2_avg_in = '0;
      end else if (s1_raw_ok) begin
         s2_avg_in = blend_avg;
      end else begin
         s2_avg_in = s1_avg_cur;
      end
   end

   // Difference stage.
   assign s2_avg_ok = depth_ok(s2_avg_ff);
   assign s2_both   = s2_in_range_ff && s2_raw_ok_ff && s2_avg_ok;

   always_comb begin
      s3_rsp_in.average_depth = s2_avg_ff;
      s3_rsp_in.both_valid    = s2_both;
      if (!s2_both) begin
         s3_rsp_in.depth_difference = '0;
      end else if (s2_avg_ff >= s2_raw_ff) begin
         s3_rsp_in.depth_difference = s2_avg_ff - s2_raw_ff;
      end else begin
         s3_rsp_in.depth_difference = s2_raw_ff - s2_avg_ff;
      end
   end

   // Average store: clearing pass after reset, then one write per update.
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         store_mem[clr_addr_ff] <= '0;
      end else if (mem_wr_en) begin
         store_mem[s1_addr_ff] <= blend_avg;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_rd_ff <= store_mem[req_addr];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff     <= WEIGHT_RESET;
         weight_inv_ff <= WEIGHT_ONE - WEIGHT_RESET;
         clearing_ff   <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            weight_ff     <= weight_in;
            weight_inv_ff <= weight_inv_in;
         end
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               clearing_ff <= 1'b0;
            end
         end
         if (s1_ready) begin
            s1_valid_ff <= req_accept;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (mem_wr_en) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_addr_ff     <= req_addr;
         s1_in_range_ff <= req_in_range;
         s1_raw_ff      <= req_data.raw_depth;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_in_range_ff <= s1_in_range_ff;
         s2_raw_ok_ff   <= s1_raw_ok;
         s2_raw_ff      <= s1_raw_ff;
         s2_avg_ff      <= s2_avg_in;
      end
      if (mem_wr_en) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_avg_ff  <= blend_avg;
      end
      if (s2_valid_ff && s3_ready) begin
         s3_rsp_ff <= s3_rsp_in;
      end
   end

   assign rsp_valid = s3_valid_ff;
   assign rsp_data  = s3_rsp_ff;

   // A reported match always carries a real average depth.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.both_valid) |->
         (rsp_data.average_depth != DEPTH_NO_DATA_LOW &&
          rsp_data.average_depth != DEPTH_NO_DATA_HIGH))
      else $error("both_valid set with a no-data average");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.both_valid) |-> (rsp_data.depth_difference == '0))
      else $error("nonzero difference without both_valid");

   // The store must be cleared before the first item is taken.
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> req_stall)
      else $error("item accepted before the clearing pass");

   assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> !clearing_ff)
      else $error("update write during the clearing pass");

endmodule
`default_nettype wire

// ===== sim/depth_background_average_diff_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Depth background average and difference testbench
// Drives pixel items through the background averaging block with random
// gaps and output stalls. A local per-pixel average store predicts every
// result, and the block's output is checked field by field in order. The
// weight register is changed between phases, the saturating values among
// them.
// ----------------------------------------------------------------------------
module depth_background_average_diff_tb;
   import dbad_pkg::*;

   localparam int FRAME_PIXELS   = FRAME_PIXELS_DEFAULT;
   localparam int WATCHDOG_LIMIT = 4 * FRAME_PIXELS + 1000;
   localparam int PHASE_ITEMS    = 210;
   localparam int HOLD_CYCLES    = 120;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   req_type             req_data    = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   rsp_type             rsp_data;
   logic                csr_wr_en   = 1'b0;
   logic [WEIGHT_W-1:0] csr_wr_data = '0;

   req_type             pending_items[$];
   rsp_type             expected_results[$];
   bit [DEPTH_W-1:0]    background_avg [0:FRAME_PIXELS-1];
   logic [WEIGHT_W-1:0] weight_setting = WEIGHT_RESET;

   int unsigned items_queued   = 0;
   int unsigned items_taken    = 0;
   int unsigned failures       = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned req_gap        = 0;
   int unsigned stall_left     = 0;
   int unsigned hold_left      = 0;
   logic        req_accepted   = 1'b0;
   logic        idle_enable    = 1'b1;
   logic        hold_request   = 1'b0;
   logic        hold_done      = 1'b0;

   depth_background_average_diff #(
      .FRAME_PIXELS(FRAME_PIXELS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic logic depth_usable(input logic [DEPTH_W-1:0] value);
      return value != DEPTH_NO_DATA_LOW && value != DEPTH_NO_DATA_HIGH;
   endfunction

   function automatic rsp_type predict_background(input req_type item);
      logic [WEIGHT_W-1:0] w;
      logic [19:0]         blend;
      logic [DEPTH_W-1:0]  avg;
      rsp_type             result;
      result = '0;
      w = (weight_setting > WEIGHT_ONE) ? WEIGHT_ONE : weight_setting;
      if (item.pixel_index < FRAME_PIXELS) begin
         avg = background_avg[item.pixel_index];
         if (depth_usable(item.raw_depth)) begin
            blend = 20'(item.raw_depth) * 20'(w) + 20'(avg) * 20'(WEIGHT_ONE - w);
            avg = blend[18:8];
            background_avg[item.pixel_index] = avg;
         end
         result.average_depth = avg;
         if (depth_usable(avg) && depth_usable(item.raw_depth)) begin
            result.depth_difference = (avg >= item.raw_depth) ? avg - item.raw_depth
                                                               : item.raw_depth - avg;
            result.both_valid = 1'b1;
         end
      end
      return result;
   endfunction

   function automatic int unsigned hot_pixel();
      if ($urandom_range(0, 1) == 0) begin
         return $urandom_range(0, 7);
      end
      return FRAME_PIXELS - 1 - $urandom_range(0, 7);
   endfunction

   task automatic report_failure(input string what, input rsp_type want, input rsp_type got);
      failures++;
      if (failures <= 10) begin
         $display("%s: expected avg=%0d diff=%0d both=%0b, got avg=%0d diff=%0d both=%0b",
                  what, want.average_depth, want.depth_difference, want.both_valid,
                  got.average_depth, got.depth_difference, got.both_valid);
      end
   endtask

   task automatic queue_item(input int unsigned index, input int unsigned raw);
      req_type item;
      item.pixel_index = index[PIXEL_INDEX_W-1:0];
      item.raw_depth   = raw[DEPTH_W-1:0];
      pending_items.push_back(item);
      items_queued++;
   endtask

   // Most items revisit a few pixels with valid depth so that averages build up.
   task automatic queue_random_item();
      int unsigned pick;
      int unsigned index;
      int unsigned raw;
      pick  = $urandom_range(0, 99);
      index = hot_pixel();
      raw   = $urandom_range(1, 2046);
      if (pick < 12) begin
         raw = ($urandom_range(0, 1) == 0) ? DEPTH_NO_DATA_LOW : DEPTH_NO_DATA_HIGH;
      end else if (pick < 22) begin
         index = $urandom_range(0, FRAME_PIXELS - 1);
         raw   = $urandom_range(0, 2047);
      end else if (pick < 32) begin
         index = $urandom_range(FRAME_PIXELS, (1 << PIXEL_INDEX_W) - 1);
         raw   = $urandom_range(0, 2047);
      end else if (pick < 37) begin
         raw = ($urandom_range(0, 1) == 0) ? 1 : 2046;
      end
      queue_item(index, raw);
   endtask

   task automatic wait_for_drain();
      do begin
         @(negedge clock);
      end while (items_taken != items_queued || expected_results.size() != 0);
   endtask

   task automatic write_weight(input logic [WEIGHT_W-1:0] value);
      wait_for_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else if (!req_valid || req_accepted) begin
         if (req_gap != 0) begin
            req_valid <= 1'b0;
            req_gap   <= req_gap - 1;
         end else if (idle_enable && $urandom_range(0, 9) == 0) begin
            req_valid <= 1'b0;
            req_gap   <= $urandom_range(0, 4);
         end else if (pending_items.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_items.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         hold_done <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : monitor
      logic    req_fire;
      logic    rsp_fire;
      rsp_type predicted;
      req_fire = !reset && req_valid && req_stall === 1'b0;
      rsp_fire = !reset && rsp_valid === 1'b1 && !rsp_stall;
      req_accepted <= req_fire;
      if (rsp_fire) begin
         if (expected_results.size() == 0) begin
            report_failure("unexpected item", '0, rsp_data);
         end else begin
            predicted = expected_results.pop_front();
            if (rsp_data.average_depth !== predicted.average_depth ||
                rsp_data.depth_difference !== predicted.depth_difference ||
                rsp_data.both_valid !== predicted.both_valid) begin
               report_failure("mismatch", predicted, rsp_data);
            end
         end
      end
      if (req_fire) begin
         expected_results.push_back(predict_background(req_data));
         items_taken++;
      end
      if (reset) begin
         weight_setting = WEIGHT_RESET;
      end else if (csr_wr_en) begin
         weight_setting = csr_wr_data;
      end
      quiet_cycles = (req_fire || rsp_fire) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic [WEIGHT_W-1:0] phase_weights [0:8];
      phase_weights = '{9'd256, 9'd0, 9'd511, 9'd1, 9'd257, 9'd255, 9'd128, 9'd64, 9'd0};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed items at the reset weight.
      queue_item(0, 1000);
      queue_item(0, 1000);
      queue_item(0, DEPTH_NO_DATA_LOW);
      queue_item(0, DEPTH_NO_DATA_HIGH);
      queue_item(FRAME_PIXELS - 1, 2046);
      queue_item(FRAME_PIXELS - 1, 1);
      queue_item(FRAME_PIXELS, 500);
      queue_item((1 << PIXEL_INDEX_W) - 1, 2046);
      queue_item(5, DEPTH_NO_DATA_LOW);
      queue_item(5, DEPTH_NO_DATA_HIGH);
      queue_item(6, 1);
      queue_item(6, 2046);
      queue_item(7, 2046);
      queue_item(7, 2046);
      queue_item(7, 2046);
      queue_item(7, 2046);
      queue_item(0, 1);
      queue_item(1, 1024);
      queue_item(1, 1024);
      queue_item(2, 3);

      for (int phase = 0; phase < 9; phase++) begin
         if (phase == 8) begin
            write_weight($urandom_range(0, 511));
            idle_enable = 1'b0;
         end else begin
            write_weight(phase_weights[phase]);
         end
         if (phase == 3) begin
            hold_request = 1'b1;
         end
         repeat (PHASE_ITEMS) queue_random_item();
      end

      wait_for_drain();
      repeat (12) @(posedge clock);
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
